### rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// First-fit segment allocator package
// Shared widths, operation and register codes, and the structs that pass
// configuration and queued commands between the allocator's modules.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  // Default geometry of the heap.
  localparam int MAX_SEGMENTS_DEF      = 64;
  localparam int TILES_PER_SEGMENT_DEF = 4;
  localparam int SEGMENT_BYTES_DEF     = 128;

  // Fixed field widths.
  localparam int ADDR_W     = 32;
  localparam int OPCODE_W   = 2;
  localparam int TILE_CNT_W = 10;
  localparam int CAP_W      = 9;
  localparam int TOTAL_W    = 9;
  localparam int CFG_IDX_W  = 2;

  // Segment index and segment count fields sized for the largest heap (1024 segments).
  localparam int SEG_IDX_W = 10;
  localparam int SEG_CNT_W = 11;

  localparam logic [CAP_W-1:0]   CAP_RESET = 9'd256;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = 9'h1FF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_CAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_ADDR  = 2'd2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic [ADDR_W-1:0] heap_start_address;
    logic [CAP_W-1:0]  heap_tile_capacity;
    logic [ADDR_W-1:0] failure_address;
  } cfg_t;

  // One classified command as it waits between the front and the back.
  typedef struct packed {
    logic [OPCODE_W-1:0]   opcode;
    logic [TILE_CNT_W-1:0] tile_count;
    logic [SEG_IDX_W-1:0]  seg_idx;
    logic                  free_hit;
    logic [SEG_CNT_W-1:0]  active_segs;
  } cmd_t;

endpackage

### rtl/ffsa_if.sv
// ----------------------------------------------------------------------------
// First-fit segment allocator channels
// Request and response valid/ready channels of the allocator.
// ----------------------------------------------------------------------------
interface ffsa_req_if;
  import ffsa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [TILE_CNT_W-1:0] tile_count;
  logic [ADDR_W-1:0]     release_address;

  modport source (output valid, output opcode, output tile_count, output release_address,
                  input ready);
  modport sink   (input valid, input opcode, input tile_count, input release_address,
                  output ready);
endinterface

interface ffsa_rsp_if;
  import ffsa_pkg::*;

  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  block_address;
  logic               granted;
  logic [TOTAL_W-1:0] allocated_tiles;

  modport source (output valid, output block_address, output granted,
                  output allocated_tiles, input ready);
  modport sink   (input valid, input block_address, input granted,
                  input allocated_tiles, output ready);
endinterface

### rtl/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// First-fit segment allocator
// Top level: configuration registers, front end, command queue and back end.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on req (opcode, tile_count, release_address) and each
// request item yields exactly one response item on rsp (block_address, granted,
// allocated_tiles). Opcode allocate rounds tile_count up to whole segments and
// takes the first free run from segment 0; free clears the entry its address
// names; clear empties the whole table. Registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i while no item is in flight.
// Timing. The front end takes an item, works out the segment a free names and
// the active segment count by reciprocal multiplication, then queues the
// command (two entries); it takes no new item until that command is queued.
// The back end reads the segment table one entry per cycle through its single
// RAM read port: an allocate skips head entries and examines the free entries
// of each candidate run, then every command ends with a walk over at most the
// active segment count of entries. A clear also writes every table entry.
// Reset. After rst_ni rises the table is swept to zero, one entry per cycle;
// req.ready stays low until the sweep ends, while configuration writes are
// taken at any time.
// Back pressure. A response waits in the output register while rsp.ready is
// low; the front end keeps taking and classifying items until the queue fills.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator #(
  parameter int MAX_SEGMENTS      = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int TILES_PER_SEGMENT = ffsa_pkg::TILES_PER_SEGMENT_DEF,
  parameter int SEGMENT_BYTES     = ffsa_pkg::SEGMENT_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ffsa_req_if.sink                       req,
  ffsa_rsp_if.source                     rsp,
  input  logic                           cfg_we_i,
  input  logic [ffsa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ffsa_pkg::ADDR_W-1:0]    cfg_data_i
);
  import ffsa_pkg::*;

  cfg_t       cfg_q;
  logic       q_valid;
  cmd_t       q_cmd;
  logic       q_pop;
  logic       init_busy;
  logic [2:0] pending_q;

  // Configuration registers; an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heap_start_address <= '0;
      cfg_q.heap_tile_capacity <= CAP_RESET;
      cfg_q.failure_address    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEAP_START: cfg_q.heap_start_address <= cfg_data_i;
        CFG_TILE_CAP:   cfg_q.heap_tile_capacity <= cfg_data_i[CAP_W-1:0];
        CFG_FAIL_ADDR:  cfg_q.failure_address    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  ffsa_front #(
    .MAX_SEGMENTS      (MAX_SEGMENTS),
    .TILES_PER_SEGMENT (TILES_PER_SEGMENT),
    .SEGMENT_BYTES     (SEGMENT_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .init_busy_i (init_busy),
    .req         (req),
    .q_valid_o   (q_valid),
    .q_cmd_o     (q_cmd),
    .q_pop_i     (q_pop)
  );

  ffsa_back #(
    .MAX_SEGMENTS      (MAX_SEGMENTS),
    .TILES_PER_SEGMENT (TILES_PER_SEGMENT),
    .SEGMENT_BYTES     (SEGMENT_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .init_busy_o (init_busy),
    .rsp         (rsp)
  );

  // Items taken but not yet answered: at most one in the front end, two queued,
  // and one either in the back end or waiting in the output register, since the
  // back end only pops when the output register empties at that edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(req.valid && req.ready) - 3'(rsp.valid && rsp.ready);
    end
  end

  a_no_accept_during_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !req.ready)
    else $error("request taken while the table is being swept");

  a_response_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (pending_q != 3'd0))
    else $error("response without an outstanding request");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more items in flight than the pipeline can hold");

  a_queue_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("command queue popped while empty");

endmodule

### rtl/ffsa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ffsa_cdiv.sv
// ----------------------------------------------------------------------------
// Divider by a constant
// Reciprocal multiplication for dividends below DIVISOR times two to the
// power QW; the quotient is registered at the edge that starts it.
// ----------------------------------------------------------------------------
module ffsa_cdiv #(
  parameter int DW      = 32,
  parameter int DIVISOR = 128,
  parameter int QW      = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  output logic          done_o,
  output logic [QW-1:0] quotient_o
);

  // Dividends in range fit in NW bits. With a shift of NW plus the divisor's
  // ceiling log2, the rounded-up reciprocal gives the exact quotient.
  localparam int NW = $clog2(DIVISOR) + QW;
  localparam int K  = NW + $clog2(DIVISOR);
  localparam longint unsigned MULT =
    ((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam int MW = $clog2(MULT + 64'd1);
  localparam int PW = NW + MW;
  localparam logic [MW-1:0] MULT_V = MW'(MULT);

  logic [NW-1:0] num;
  logic [PW-1:0] prod;
  logic          done_q;
  logic [QW-1:0] quo_q;

  assign num  = NW'(dividend_i);
  assign prod = PW'(num) * PW'(MULT_V);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (start_i) begin
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= QW'(prod >> K);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/ffsa_front.sv
// ----------------------------------------------------------------------------
// Allocator front end
// Accepts request items, works out the segment a free names and the number
// of active segments, and queues the classified command for the back end.
// ----------------------------------------------------------------------------
module ffsa_front #(
  parameter int MAX_SEGMENTS      = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int TILES_PER_SEGMENT = ffsa_pkg::TILES_PER_SEGMENT_DEF,
  parameter int SEGMENT_BYTES     = ffsa_pkg::SEGMENT_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffsa_pkg::cfg_t  cfg_i,
  input  logic            init_busy_i,
  ffsa_req_if.sink        req,
  output logic            q_valid_o,
  output ffsa_pkg::cmd_t  q_cmd_o,
  input  logic            q_pop_i
);
  import ffsa_pkg::*;

  localparam int SEG_QW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [ADDR_W:0] SPAN = (ADDR_W + 1)'(MAX_SEGMENTS * SEGMENT_BYTES);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CALC = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;

  localparam int QDEPTH = 2;

  logic [1:0] state_q, state_d;

  logic [OPCODE_W-1:0]   op_q;
  logic [TILE_CNT_W-1:0] tiles_q;
  logic [ADDR_W-1:0]     rel_q;
  logic                  in_range_q, in_range_d;
  logic                  nomatch_q, nomatch_d;
  logic [ADDR_W-1:0]     diff;

  logic                  div_start;
  logic                  seg_done, cap_done;
  logic [SEG_QW-1:0]     seg_quo;
  logic [CAP_W-1:0]      cap_quo;

  logic                  accept, push;
  cmd_t                  push_cmd;
  cmd_t                  q_mem_q [QDEPTH];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            count_q;

  assign diff   = rel_q - cfg_i.heap_start_address;
  assign accept = req.valid && req.ready;

  always_comb begin
    state_d    = state_q;
    in_range_d = in_range_q;
    nomatch_d  = nomatch_q;
    div_start  = 1'b0;
    push       = 1'b0;
    req.ready  = (state_q == F_IDLE) && !init_busy_i;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_CALC;
        end
      end
      F_CALC: begin
        div_start  = 1'b1;
        in_range_d = ({1'b0, diff} < SPAN);
        nomatch_d  = (rel_q != cfg_i.failure_address);
        state_d    = F_DIV;
      end
      F_DIV: begin
        if (seg_done && cap_done && (count_q != 2'(QDEPTH))) begin
          push    = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  ffsa_cdiv #(
    .DW      (ADDR_W),
    .DIVISOR (SEGMENT_BYTES),
    .QW      (SEG_QW)
  ) u_seg_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff),
    .done_o     (seg_done),
    .quotient_o (seg_quo)
  );

  ffsa_cdiv #(
    .DW      (CAP_W),
    .DIVISOR (TILES_PER_SEGMENT),
    .QW      (CAP_W)
  ) u_cap_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cfg_i.heap_tile_capacity),
    .done_o     (cap_done),
    .quotient_o (cap_quo)
  );

  always_comb begin
    push_cmd.opcode      = op_q;
    push_cmd.tile_count  = tiles_q;
    push_cmd.seg_idx     = SEG_IDX_W'(seg_quo);
    push_cmd.free_hit    = in_range_q && nomatch_q;
    push_cmd.active_segs = (32'(cap_quo) > 32'(MAX_SEGMENTS)) ? SEG_CNT_W'(MAX_SEGMENTS)
                                                              : SEG_CNT_W'(cap_quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      state_q <= state_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= req.opcode;
      tiles_q <= req.tile_count;
      rel_q   <= req.release_address;
    end
    in_range_q <= in_range_d;
    nomatch_q  <= nomatch_d;
    if (push) begin
      q_mem_q[wr_ptr_q] <= push_cmd;
    end
  end

  assign q_valid_o = (count_q != '0);
  assign q_cmd_o   = q_mem_q[rd_ptr_q];

endmodule

### rtl/ffsa_back.sv
// ----------------------------------------------------------------------------
// Allocator back end
// Runs queued commands against the segment table: first-fit scan, free,
// clear, then a walk that totals the allocated segments for the response.
// ----------------------------------------------------------------------------
module ffsa_back #(
  parameter int MAX_SEGMENTS      = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int TILES_PER_SEGMENT = ffsa_pkg::TILES_PER_SEGMENT_DEF,
  parameter int SEGMENT_BYTES     = ffsa_pkg::SEGMENT_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ffsa_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  input  ffsa_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           init_busy_o,
  ffsa_rsp_if.source     rsp
);
  import ffsa_pkg::*;

  localparam int AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int EW   = $clog2(MAX_SEGMENTS + 1);
  localparam int IW   = $clog2(2 * MAX_SEGMENTS);
  localparam int RUNW = $clog2(MAX_SEGMENTS * TILES_PER_SEGMENT + 1);
  localparam int CW   = (RUNW > TILE_CNT_W) ? RUNW : TILE_CNT_W;

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_AHEAD  = 3'd1;
  localparam logic [2:0] B_ARUN   = 3'd2;
  localparam logic [2:0] B_WSTART = 3'd3;
  localparam logic [2:0] B_WRUN   = 3'd4;
  localparam logic [2:0] B_CLR    = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic               clr_item_q, clr_item_d;
  logic               out_valid_q, out_valid_d;

  cmd_t               cmd_q, cmd_d;
  logic [IW-1:0]      i_q, i_d;
  logic [IW-1:0]      p_q, p_d;
  logic [EW-1:0]      j_q, j_d;
  logic [CW-1:0]      run_q, run_d;
  logic [IW-1:0]      sum_q, sum_d;
  logic               grant_q, grant_d;
  logic [ADDR_W-1:0]  prod_q, prod_d;
  logic [ADDR_W-1:0]  out_addr_q, out_addr_d;
  logic               out_grant_q, out_grant_d;
  logic [TOTAL_W-1:0] out_tiles_q, out_tiles_d;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [EW-1:0]      wdata;
  logic [IW-1:0]      raddr_full;
  logic [EW-1:0]      rdata;
  logic [IW-1:0]      rdata_w;
  logic [IW-1:0]      n_w;
  logic [CW-1:0]      tiles_w;
  logic [IW-1:0]      i_jump, i_inc;
  logic [IW-1:0]      base_p, adv_p;
  logic [EW-1:0]      base_j, adv_j;
  logic [CW-1:0]      base_run, adv_run;
  logic [ADDR_W-1:0]  total_w;

  assign rdata_w = IW'(rdata);
  assign n_w     = IW'(cmd_q.active_segs);
  assign tiles_w = CW'(cmd_q.tile_count);
  assign i_jump  = i_q + rdata_w;
  assign i_inc   = i_q + IW'(1);

  // A run starts at the candidate entry itself, or continues from the last free entry.
  assign base_p   = (state_q == B_ARUN) ? p_q : i_q;
  assign base_j   = (state_q == B_ARUN) ? j_q : '0;
  assign base_run = (state_q == B_ARUN) ? run_q : '0;
  assign adv_p    = base_p + IW'(1);
  assign adv_j    = base_j + EW'(1);
  assign adv_run  = base_run + CW'(TILES_PER_SEGMENT);

  assign total_w = ADDR_W'(sum_q) * ADDR_W'(TILES_PER_SEGMENT);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    clr_item_d  = clr_item_q;
    out_valid_d = out_valid_q && !rsp.ready;
    cmd_d       = cmd_q;
    i_d         = i_q;
    p_d         = p_q;
    j_d         = j_q;
    run_d       = run_q;
    sum_d       = sum_q;
    grant_d     = grant_q;
    prod_d      = prod_q;
    out_addr_d  = out_addr_q;
    out_grant_d = out_grant_q;
    out_tiles_d = out_tiles_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr_full  = '0;
    q_pop_o     = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i && (!out_valid_q || rsp.ready)) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          grant_d = 1'b0;
          i_d     = '0;
          case (q_cmd_i.opcode)
            OP_ALLOC: begin
              state_d = B_AHEAD;
            end
            OP_FREE: begin
              if (q_cmd_i.free_hit) begin
                we    = 1'b1;
                waddr = q_cmd_i.seg_idx[AW-1:0];
              end
              state_d = B_WSTART;
            end
            OP_CLEAR: begin
              clr_d      = '0;
              clr_item_d = 1'b1;
              state_d    = B_CLR;
            end
            default: begin
              state_d = B_WSTART;
            end
          endcase
        end
      end
      B_AHEAD, B_ARUN: begin
        if ((state_q == B_AHEAD) && (i_q >= n_w)) begin
          state_d = B_WSTART;
        end else if ((state_q == B_AHEAD) && (rdata != '0)) begin
          i_d        = i_jump;
          raddr_full = i_jump;
        end else if ((state_q == B_ARUN) && (rdata != '0)) begin
          i_d        = i_inc;
          raddr_full = i_inc;
          state_d    = B_AHEAD;
        end else if ((state_q == B_AHEAD) && (cmd_q.tile_count == '0)) begin
          grant_d = 1'b1;
          prod_d  = ADDR_W'(i_q) * ADDR_W'(SEGMENT_BYTES);
          state_d = B_WSTART;
        end else if (adv_run >= tiles_w) begin
          we      = 1'b1;
          waddr   = i_q[AW-1:0];
          wdata   = adv_j;
          grant_d = 1'b1;
          prod_d  = ADDR_W'(i_q) * ADDR_W'(SEGMENT_BYTES);
          state_d = B_WSTART;
        end else if (adv_p >= n_w) begin
          state_d = B_WSTART;
        end else begin
          p_d        = adv_p;
          j_d        = adv_j;
          run_d      = adv_run;
          raddr_full = adv_p;
          state_d    = B_ARUN;
        end
      end
      B_WSTART: begin
        i_d     = '0;
        sum_d   = '0;
        state_d = B_WRUN;
      end
      B_WRUN: begin
        if (i_q >= n_w) begin
          out_valid_d = 1'b1;
          if (cmd_q.opcode == OP_ALLOC) begin
            out_addr_d = grant_q ? (cfg_i.heap_start_address + prod_q)
                                 : cfg_i.failure_address;
          end else begin
            out_addr_d = '0;
          end
          out_grant_d = grant_q && (cmd_q.opcode == OP_ALLOC);
          out_tiles_d = (total_w > ADDR_W'(TOTAL_SAT)) ? TOTAL_SAT : total_w[TOTAL_W-1:0];
          state_d     = B_IDLE;
        end else if (rdata != '0) begin
          sum_d      = sum_q + rdata_w;
          i_d        = i_jump;
          raddr_full = i_jump;
        end else begin
          i_d        = i_inc;
          raddr_full = i_inc;
        end
      end
      B_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(MAX_SEGMENTS - 1)) begin
          state_d = clr_item_q ? B_WSTART : B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  ffsa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_full[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      clr_q       <= '0;
      clr_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_item_q  <= clr_item_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    i_q         <= i_d;
    p_q         <= p_d;
    j_q         <= j_d;
    run_q       <= run_d;
    sum_q       <= sum_d;
    grant_q     <= grant_d;
    prod_q      <= prod_d;
    out_addr_q  <= out_addr_d;
    out_grant_q <= out_grant_d;
    out_tiles_q <= out_tiles_d;
  end

  assign init_busy_o         = (state_q == B_CLR) && !clr_item_q;
  assign rsp.valid           = out_valid_q;
  assign rsp.block_address   = out_addr_q;
  assign rsp.granted         = out_grant_q;
  assign rsp.allocated_tiles = out_tiles_q;

endmodule

### tb/sv/ffsa_result_check.sv
// ----------------------------------------------------------------------------
// First-fit segment allocator result checker
// Watches the request, response and register write ports, keeps its own copy
// of the segment table and the registers, works out each response and compares
// it field by field with what the allocator returns.
// ----------------------------------------------------------------------------
module ffsa_result_check
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS      = MAX_SEGMENTS_DEF,
  parameter int TILES_PER_SEGMENT = TILES_PER_SEGMENT_DEF,
  parameter int SEGMENT_BYTES     = SEGMENT_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ffsa_req_if                  req,
  ffsa_rsp_if                  rsp,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          checked_o,
  output int unsigned          grants_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ADDR_W-1:0]  block_address;
    logic               granted;
    logic [TOTAL_W-1:0] allocated_tiles;
  } alloc_result_t;

  alloc_result_t     expected_results[$];
  int unsigned       seg_len[MAX_SEGMENTS];
  logic [ADDR_W-1:0] heap_base;
  logic [CAP_W-1:0]  tile_cap;
  logic [ADDR_W-1:0] fail_addr;
  int unsigned       mismatches;
  int unsigned       checked;
  int unsigned       grants;

  function automatic int unsigned active_count();
    int unsigned n;
    n = tile_cap / TILES_PER_SEGMENT;
    return (n > MAX_SEGMENTS) ? MAX_SEGMENTS : n;
  endfunction

  // Walks the heads within the active segments and sums their lengths.
  function automatic int unsigned held_segments();
    int unsigned n;
    int unsigned i;
    int unsigned sum;
    n   = active_count();
    i   = 0;
    sum = 0;
    while (i < n) begin
      if (seg_len[i] != 0) begin
        sum += seg_len[i];
        i   += seg_len[i];
      end else begin
        i++;
      end
    end
    return sum;
  endfunction

  // First-fit search. A run cut short by a block resumes one segment further
  // on; a run that reaches the end of the active heap ends the search.
  function automatic bit first_fit(input int unsigned tiles, output int unsigned seg);
    int unsigned n;
    int unsigned need;
    int unsigned i;
    int unsigned j;
    bit          blocked;
    n    = active_count();
    need = (tiles + TILES_PER_SEGMENT - 1) / TILES_PER_SEGMENT;
    i    = 0;
    seg  = 0;
    while (i < n) begin
      if (seg_len[i] == 0) begin
        blocked = 1'b0;
        for (j = 0; j < need; j++) begin
          if (i + j >= n) return 1'b0;
          if (seg_len[i + j] != 0) begin
            blocked = 1'b1;
            break;
          end
        end
        if (!blocked) begin
          if (need != 0) seg_len[i] = need;
          seg = i;
          return 1'b1;
        end
        i++;
      end else begin
        i += seg_len[i];
      end
    end
    return 1'b0;
  endfunction

  function automatic alloc_result_t predict_result(input logic [OPCODE_W-1:0]   op,
                                                   input logic [TILE_CNT_W-1:0] tiles,
                                                   input logic [ADDR_W-1:0]     rel);
    alloc_result_t res;
    int unsigned   seg;
    int unsigned   total;
    logic [ADDR_W-1:0] offset;
    res = '0;
    case (op)
      OP_ALLOC: begin
        if (first_fit(tiles, seg)) begin
          res.block_address = heap_base + ADDR_W'(seg * SEGMENT_BYTES);
          res.granted       = 1'b1;
        end else begin
          res.block_address = fail_addr;
        end
      end
      OP_FREE: begin
        if (rel != fail_addr) begin
          offset = rel - heap_base;
          seg    = offset / SEGMENT_BYTES;
          if (seg < MAX_SEGMENTS) seg_len[seg] = 0;
        end
      end
      OP_CLEAR: begin
        foreach (seg_len[k]) seg_len[k] = 0;
      end
      default: ;
    endcase
    total = held_segments() * TILES_PER_SEGMENT;
    res.allocated_tiles = (total > TOTAL_SAT) ? TOTAL_SAT : TOTAL_W'(total);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    $display("%0t ns: response %0d %s mismatch: got 0x%0h, expected 0x%0h",
             $realtime, checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      foreach (seg_len[k]) seg_len[k] = 0;
      heap_base    = '0;
      tile_cap     = CAP_RESET;
      fail_addr    = '0;
      mismatches   = 0;
      checked      = 0;
      grants       = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      grants_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HEAP_START: heap_base = cfg_data_i;
          CFG_TILE_CAP:   tile_cap  = cfg_data_i[CAP_W-1:0];
          CFG_FAIL_ADDR:  fail_addr = cfg_data_i;
          default: ;
        endcase
      end
      // Responses are checked before this edge's request is predicted, so a
      // stray response can never consume a fresh expectation.
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected response", rsp.block_address, '0);
        end else begin
          alloc_result_t want;
          want = expected_results.pop_front();
          if (rsp.block_address !== want.block_address)
            report_mismatch("block_address", rsp.block_address, want.block_address);
          if (rsp.granted !== want.granted)
            report_mismatch("granted", ADDR_W'(rsp.granted), ADDR_W'(want.granted));
          if (rsp.allocated_tiles !== want.allocated_tiles)
            report_mismatch("allocated_tiles", ADDR_W'(rsp.allocated_tiles),
                            ADDR_W'(want.allocated_tiles));
        end
        if (rsp.granted === 1'b1) grants++;
        checked++;
      end
      if (req.valid && req.ready)
        expected_results.push_back(predict_result(req.opcode, req.tile_count,
                                                  req.release_address));
      fail_count_o <= mismatches;
      pending_o    <= expected_results.size();
      checked_o    <= checked;
      grants_o     <= grants;
    end
  end

endmodule

### tb/sv/first_fit_segment_allocator_test.sv
// ----------------------------------------------------------------------------
// First-fit segment allocator testbench
// Drives allocate, free and clear requests through six heap configurations,
// with random idling on both channels, a long response stall and a full
// drain, while a result checker predicts and compares every response.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ffsa_pkg::*;

  localparam int unsigned SEG_BYTES  = SEGMENT_BYTES_DEF;
  localparam int unsigned TILES_SEG  = TILES_PER_SEGMENT_DEF;
  localparam int unsigned SEGS_MAX   = MAX_SEGMENTS_DEF;
  // Upper bound on the whole run. A worst-case allocate rescans candidate runs
  // from each free entry in turn; real runs stay far below this bound.
  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  // Cycles allowed after the last response before registers change or the
  // run ends; covers the divider front end, a full table walk and a clear.
  localparam int unsigned SETTLE     = 200;
  localparam int unsigned LONG_HOLD  = 400;
  // The opcode that the allocator must treat as a no-op.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ADDR_W-1:0]    cfg_data_i;

  ffsa_req_if req_ch ();
  ffsa_rsp_if rsp_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned grants;

  // Stimulus knobs. The response idle rate and the long hold request are read
  // by the ready process, so they only change through nonblocking writes.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        long_hold_q;
  int unsigned items_sent;
  int unsigned cycles;

  // Current register values as seen by the stimulus, used to aim frees.
  logic [ADDR_W-1:0] cur_base;
  logic [ADDR_W-1:0] cur_fail;
  int unsigned       cur_segs;

  first_fit_segment_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  ffsa_result_check result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .grants_o     (grants)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Global watchdog: a stuck handshake or a lost response ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d responses outstanding.", cycles, pending);
    $display("** first_fit_segment_allocator: FAILED **");
    $finish;
  end

  // Response side. Normally ready is random at the current idle rate. Once
  // the stimulus raises long_hold_q, ready is held low for a hold set by LONG_HOLD
  // and counted here, so the command queue fills and the request side stalls.
  initial begin
    int unsigned hold_left;
    bit          hold_used;
    hold_left    = 0;
    hold_used    = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (long_hold_q && !hold_used) begin
        hold_used    = 1'b1;
        hold_left    = LONG_HOLD - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Writes all three registers on consecutive edges. The write enable stays
  // high across the burst and drops once at the end.
  task automatic write_config(input logic [ADDR_W-1:0] base, input logic [CAP_W-1:0] cap,
                              input logic [ADDR_W-1:0] fail);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_HEAP_START;
    cfg_data_i <= base;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TILE_CAP;
    cfg_data_i <= ADDR_W'(cap);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FAIL_ADDR;
    cfg_data_i <= fail;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_base = base;
    cur_fail = fail;
    cur_segs = (cap / TILES_SEG > SEGS_MAX) ? SEGS_MAX : cap / TILES_SEG;
  endtask

  // Offers one request item, after a random number of idle cycles, and
  // returns at the edge that accepts it with valid still high.
  task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [TILE_CNT_W-1:0] tiles,
                         input logic [ADDR_W-1:0] rel);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid           <= 1'b1;
    req_ch.opcode          <= op;
    req_ch.tile_count      <= tiles;
    req_ch.release_address <= rel;
    do @(posedge clk_i); while (!req_ch.ready);
    items_sent++;
  endtask

  // Stops offering, waits for every outstanding response, then lets the
  // back end settle so registers can change safely.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Mostly small allocates and frees aimed at segment boundaries, so the
  // table fills, fragments and empties again; the rest is clears, the unused
  // opcode and fully random items.
  task automatic random_ops(input int unsigned count);
    int unsigned           pick;
    int unsigned           sel;
    logic [OPCODE_W-1:0]   op;
    logic [TILE_CNT_W-1:0] tiles;
    logic [ADDR_W-1:0]     rel;
    repeat (count) begin
      pick  = $urandom_range(99);
      sel   = $urandom_range(9);
      tiles = TILE_CNT_W'($urandom_range(1023));
      rel   = $urandom;
      if (pick < 50) begin
        op = OP_ALLOC;
        if (sel < 7)      tiles = TILE_CNT_W'($urandom_range(16));
        else if (sel == 9) tiles = TILE_CNT_W'(cur_segs * TILES_SEG);
      end else if (pick < 85) begin
        op = OP_FREE;
        if (sel < 6)
          rel = cur_base + ADDR_W'($urandom_range(cur_segs + 1) * SEG_BYTES);
        else if (sel < 8)
          rel = cur_base + ADDR_W'($urandom_range((SEGS_MAX + 4) * SEG_BYTES));
        else if (sel == 8)
          rel = cur_fail;
      end else if (pick < 90) begin
        op = OP_CLEAR;
      end else if (pick < 95) begin
        op = OP_UNUSED;
      end else begin
        op = OPCODE_W'($urandom_range(3));
      end
      send_op(op, tiles, rel);
    end
  endtask

  task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [CAP_W-1:0] cap,
                           input logic [ADDR_W-1:0] fail, input int unsigned send_pct,
                           input int unsigned recv_pct, input int unsigned count);
    write_config(base, cap, fail);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    random_ops(count);
    wait_idle();
  endtask

  initial begin
    // Every input is known from time zero, while reset is held low at the start.
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CFG_HEAP_START;
    cfg_data_i             = '0;
    req_ch.valid           = 1'b0;
    req_ch.opcode          = OP_ALLOC;
    req_ch.tile_count      = '0;
    req_ch.release_address = '0;
    send_idle_pct          = 21;
    recv_idle_pct          = 66;
    long_hold_q            = 1'b0;
    items_sent             = 0;
    cur_base               = '0;
    cur_fail               = '0;
    cur_segs               = SEGS_MAX;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on a heap based at zero with 64 active segments. Register
    // writes are accepted during the post-reset table sweep; the first request
    // simply waits for ready.
    write_config('0, CAP_RESET, '1);
    send_op(OP_ALLOC, 10'd0, '0);                           // zero tiles: first free, no mark
    send_op(OP_ALLOC, 10'd1, '0);                           // segment 0, one segment
    send_op(OP_ALLOC, 10'd4, '0);                           // segment 1, exactly one segment
    send_op(OP_ALLOC, 10'd5, '0);                           // segments 2 and 3
    send_op(OP_ALLOC, '1, '0);                              // far beyond the heap: fails
    send_op(OP_ALLOC, 10'd256, '0);                         // free run reaches the end: fails
    send_op(OP_FREE, 10'd0, cur_base + SEG_BYTES);          // frees segment 1
    send_op(OP_ALLOC, 10'd8, '0);                           // run at 1 hits the block at 2
    send_op(OP_ALLOC, 10'd2, '0);                           // refills segment 1
    send_op(OP_FREE, '1, cur_fail);                         // failure address: ignored
    send_op(OP_FREE, 10'd0, cur_base + 2 * SEG_BYTES + 5);  // unaligned: clears its segment
    send_op(OP_FREE, 10'd0, cur_base + SEGS_MAX * SEG_BYTES); // past the table: ignored
    send_op(OP_FREE, 10'd0, cur_base - SEG_BYTES);          // below the base wraps: ignored
    send_op(OP_FREE, 10'd0, cur_base + 5 * SEG_BYTES);      // inside a block, not its head
    send_op(OP_UNUSED, '1, 32'hFFFF_FFFE);                  // unused opcode: no change
    send_op(OP_ALLOC, 10'd0, '0);                           // zero tiles lands on the gap
    send_op(OP_CLEAR, '1, '1);                              // empties the table
    send_op(OP_ALLOC, 10'd256, '0);                         // the whole heap in one block
    send_op(OP_ALLOC, 10'd0, '0);                           // zero tiles on a full heap fails
    send_op(OP_ALLOC, 10'd1, '0);                           // full heap: fails
    send_op(OP_FREE, '1, cur_base);                         // releases the whole heap
    send_op(OP_ALLOC, 10'd255, 32'h5555_AAAA);              // 64 segments again
    send_op(OP_CLEAR, 10'd0, 32'hAAAA_5555);
    random_ops(60);
    wait_idle();

    // Base near the top of the address space, so block addresses wrap; the
    // failure address is zero, which equals the address of segment 32.
    run_phase(32'hFFFF_F000, CAP_RESET, '0, 21, 66, 75);

    // The sender is now the slow side. No active segments at all: every
    // allocate fails, while frees still reach stale entries.
    run_phase($urandom, '0, $urandom, 66, 21, 50);
    // A short heap of nine segments with blocks left over from before.
    run_phase(32'h1000_0000, 9'd37, $urandom, 66, 21, 80);

    // No idling from here. An unaligned base; the long response hold starts
    // with this phase while requests keep coming, so the input stalls.
    long_hold_q <= 1'b1;
    run_phase($urandom | 32'h3, 9'd100, 32'h8000_0000, 0, 0, 90);

    // Full heap again. Halfway through the sender pauses until every
    // response is back, then resumes.
    write_config('0, CAP_RESET, '1);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    random_ops(40);
    wait_idle();
    random_ops(40);
    wait_idle();

    $display("Sent %0d request items over six heap configurations; %0d responses checked,",
             items_sent, checked);
    $display("%0d allocations granted, %0d mismatches.", grants, fail_count);
    if (fail_count == 0) begin
      $display("** first_fit_segment_allocator: PASSED **");
    end else begin
      $display("** first_fit_segment_allocator: FAILED **");
    end
    $finish;
  end

endmodule
